// ===== rtl/core/morse_key_decoder_macros.svh =====
// Assertion macros for the Morse key decoder.
// Both macros expect clk_i and rst_ni in scope.
`ifndef MORSE_KEY_DECODER_MACROS_SVH
`define MORSE_KEY_DECODER_MACROS_SVH

// Same-cycle implication, checked outside reset.
`define MKD_ASSERT_NOW(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, checked outside reset.
`define MKD_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error(msg);

`endif

// ===== rtl/core/mkd_pkg.sv =====
// ---------------------------------------------------------------------------
// mkd_pkg
// Shared types, constants and the Morse symbol table of the key decoder.
// ---------------------------------------------------------------------------
`default_nettype none

package mkd_pkg;

  localparam int unsigned MAX_ELEMENTS_DEF = 5;
  localparam int unsigned ACTION_W         = 2;
  localparam int unsigned TICKS_W          = 16;
  localparam int unsigned CHAR_W           = 7;
  localparam int unsigned HELD_W           = 3;
  localparam int unsigned LOOKUP_LEN_W     = 4;
  localparam int unsigned LOOKUP_PAT_W     = 8;
  localparam int unsigned SYM_COUNT        = 36;
  localparam int unsigned SYM_LEN_MAX      = 5;

  localparam logic [TICKS_W-1:0] DASH_THRESHOLD_RST = 16'd500;
  localparam logic [TICKS_W-1:0] TICKS_MAX          = 16'hFFFF;
  localparam logic [CHAR_W-1:0]  CHAR_UNKNOWN       = 7'h3F;

  typedef enum logic [ACTION_W-1:0] {
    ACT_TICK   = 2'd0,
    ACT_COMMIT = 2'd1,
    ACT_CLEAR  = 2'd2
  } action_e;

  typedef struct packed {
    logic [2:0]        len;
    logic [4:0]        pat;
    logic [CHAR_W-1:0] ch;
  } sym_t;

  // Pattern: first element in the most significant used bit, dash = 1.
  localparam sym_t SymTable [SYM_COUNT] = '{
    '{3'd2, 5'h01, 7'h41}, '{3'd4, 5'h08, 7'h42}, '{3'd4, 5'h0A, 7'h43},
    '{3'd3, 5'h04, 7'h44}, '{3'd1, 5'h00, 7'h45}, '{3'd4, 5'h02, 7'h46},
    '{3'd3, 5'h06, 7'h47}, '{3'd4, 5'h00, 7'h48}, '{3'd2, 5'h00, 7'h49},
    '{3'd4, 5'h07, 7'h4A}, '{3'd3, 5'h05, 7'h4B}, '{3'd4, 5'h04, 7'h4C},
    '{3'd2, 5'h03, 7'h4D}, '{3'd2, 5'h02, 7'h4E}, '{3'd3, 5'h07, 7'h4F},
    '{3'd4, 5'h06, 7'h50}, '{3'd4, 5'h0D, 7'h51}, '{3'd3, 5'h02, 7'h52},
    '{3'd3, 5'h00, 7'h53}, '{3'd1, 5'h01, 7'h54}, '{3'd3, 5'h01, 7'h55},
    '{3'd4, 5'h01, 7'h56}, '{3'd3, 5'h03, 7'h57}, '{3'd4, 5'h09, 7'h58},
    '{3'd4, 5'h0B, 7'h59}, '{3'd4, 5'h0C, 7'h5A},
    '{3'd5, 5'h1F, 7'h30}, '{3'd5, 5'h0F, 7'h31}, '{3'd5, 5'h07, 7'h32},
    '{3'd5, 5'h03, 7'h33}, '{3'd5, 5'h01, 7'h34}, '{3'd5, 5'h00, 7'h35},
    '{3'd5, 5'h10, 7'h36}, '{3'd5, 5'h18, 7'h37}, '{3'd5, 5'h1C, 7'h38},
    '{3'd5, 5'h1E, 7'h39}
  };

  // Match the buffered elements against the table; '?' when nothing fits.
  function automatic logic [CHAR_W-1:0] sym_lookup(
    input logic [LOOKUP_LEN_W-1:0] len,
    input logic [LOOKUP_PAT_W-1:0] pat,
    input logic                    overflow
  );
    logic [CHAR_W-1:0] ch;
    ch = CHAR_UNKNOWN;
    if (!overflow && (len != '0) && (len <= LOOKUP_LEN_W'(SYM_LEN_MAX))) begin
      for (int i = 0; i < SYM_COUNT; i++) begin
        if (({1'b0, SymTable[i].len} == len) &&
            ({3'b000, SymTable[i].pat} == pat)) begin
          ch = SymTable[i].ch;
        end
      end
    end
    return ch;
  endfunction

endpackage

`default_nettype wire

// ===== rtl/core/mkd_chan_if.sv =====
// ---------------------------------------------------------------------------
// mkd_chan_if
// Valid/ready channels of the Morse key decoder: input, result, config.
// ---------------------------------------------------------------------------
`default_nettype none

interface mkd_in_if;
  logic                          valid;
  logic                          ready;
  logic [mkd_pkg::ACTION_W-1:0]  action;
  logic                          key_down;

  modport source (output valid, output action, output key_down, input ready);
  modport sink   (input valid, input action, input key_down, output ready);
endinterface

interface mkd_out_if;
  logic                          valid;
  logic                          ready;
  logic                          led_on;
  logic                          element_valid;
  logic                          element_is_dash;
  logic                          char_valid;
  logic [mkd_pkg::CHAR_W-1:0]    character;
  logic [mkd_pkg::HELD_W-1:0]    elements_held;
  logic                          overflowed;

  modport source (
    output valid, output led_on, output element_valid, output element_is_dash,
    output char_valid, output character, output elements_held, output overflowed,
    input  ready
  );
  modport sink (
    input  valid, input led_on, input element_valid, input element_is_dash,
    input  char_valid, input character, input elements_held, input overflowed,
    output ready
  );
endinterface

interface mkd_cfg_if;
  logic                          valid;
  logic                          ready;
  logic [mkd_pkg::TICKS_W-1:0]   data;

  modport source (output valid, output data, input ready);
  modport sink   (input valid, input data, output ready);
endinterface

`default_nettype wire

// ===== rtl/core/morse_key_decoder.sv =====
// ---------------------------------------------------------------------------
// morse_key_decoder
// Turns ticked key levels into dots, dashes and decoded ASCII characters.
// ---------------------------------------------------------------------------
// Each input item is a millisecond tick carrying the debounced key level, a
// commit, or a clear; every item yields exactly one result item with the lamp
// state, the element appended on a release, the character decoded on a
// commit, the buffer fill and the overflow flag. An item passes through the
// input register and then the result register, and a new item is taken every
// cycle while the result register is not stalled; the combinational state update
// (press counter, threshold compare, symbol table match) sets that rate.
// The result register stalls only when the sink holds ready low. The dash
// threshold is written through the config channel, which is always ready, and
// should be changed only while no item is in flight.
`default_nettype none

`include "morse_key_decoder_macros.svh"

module morse_key_decoder #(
  parameter int unsigned MAX_ELEMENTS = mkd_pkg::MAX_ELEMENTS_DEF
) (
  input  wire logic clk_i,
  input  wire logic rst_ni,
  mkd_in_if.sink    in_i,
  mkd_out_if.source out_o,
  mkd_cfg_if.sink   cfg_i
);
  import mkd_pkg::*;

  localparam int unsigned CntW = $clog2(MAX_ELEMENTS + 1);

  // Input register
  logic                in_valid_q;
  logic [ACTION_W-1:0] act_q;
  logic                key_q;

  // Decoder state
  logic                    key_held_q, key_held_d;
  logic [TICKS_W-1:0]      press_q, press_d;
  logic [MAX_ELEMENTS-1:0] elem_bits_q, elem_bits_d;
  logic [CntW-1:0]         elem_cnt_q, elem_cnt_d;
  logic                    ovf_q, ovf_d;
  logic [TICKS_W-1:0]      thresh_q;

  // Result register
  logic              out_valid_q;
  logic              led_q, led_d;
  logic              ev_q, ev_d;
  logic              edash_q, edash_d;
  logic              cv_q, cv_d;
  logic [CHAR_W-1:0] ch_q, ch_d;

  logic advance;
  logic dash;

  // Advance the pipe when the result slot is free or being drained.
  assign advance     = in_valid_q && (!out_valid_q || out_o.ready);
  assign in_i.ready  = !in_valid_q || advance;
  assign cfg_i.ready = 1'b1;

  assign dash = (press_q > thresh_q);

  always_comb begin
    key_held_d  = key_held_q;
    press_d     = press_q;
    elem_bits_d = elem_bits_q;
    elem_cnt_d  = elem_cnt_q;
    ovf_d       = ovf_q;
    ev_d        = 1'b0;
    edash_d     = 1'b0;
    cv_d        = 1'b0;
    ch_d        = '0;
    case (act_q)
      ACT_TICK: begin
        if (key_q) begin
          if (!key_held_q) begin
            // First tick of a press counts as tick one.
            key_held_d = 1'b1;
            press_d    = TICKS_W'(1);
          end else if (press_q != TICKS_MAX) begin
            press_d = press_q + TICKS_W'(1);
          end
        end else if (key_held_q) begin
          // Release: classify and append, or drop and flag when full.
          key_held_d = 1'b0;
          press_d    = '0;
          if (elem_cnt_q < CntW'(MAX_ELEMENTS)) begin
            elem_bits_d = {elem_bits_q[MAX_ELEMENTS-2:0], dash};
            elem_cnt_d  = elem_cnt_q + CntW'(1);
            ev_d        = 1'b1;
            edash_d     = dash;
          end else begin
            ovf_d = 1'b1;
          end
        end
      end
      ACT_COMMIT: begin
        cv_d        = 1'b1;
        ch_d        = sym_lookup(LOOKUP_LEN_W'(elem_cnt_q),
                                 LOOKUP_PAT_W'(elem_bits_q), ovf_q);
        elem_bits_d = '0;
        elem_cnt_d  = '0;
        ovf_d       = 1'b0;
      end
      ACT_CLEAR: begin
        elem_bits_d = '0;
        elem_cnt_d  = '0;
        ovf_d       = 1'b0;
      end
      default: begin
        // Unused code: report status only.
      end
    endcase
    // Lamp follows the state after this item.
    led_d = key_held_d && (press_d <= thresh_q);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_q  <= 1'b0;
      out_valid_q <= 1'b0;
      key_held_q  <= 1'b0;
      press_q     <= '0;
      elem_bits_q <= '0;
      elem_cnt_q  <= '0;
      ovf_q       <= 1'b0;
      thresh_q    <= DASH_THRESHOLD_RST;
    end else begin
      if (cfg_i.valid) begin
        thresh_q <= cfg_i.data;
      end
      if (in_i.valid && in_i.ready) begin
        in_valid_q <= 1'b1;
      end else if (advance) begin
        in_valid_q <= 1'b0;
      end
      if (advance) begin
        out_valid_q <= 1'b1;
        key_held_q  <= key_held_d;
        press_q     <= press_d;
        elem_bits_q <= elem_bits_d;
        elem_cnt_q  <= elem_cnt_d;
        ovf_q       <= ovf_d;
      end else if (out_o.ready) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  // Payload registers: hold while stalled; the input payload loads on an accepted item, the result payload on advance.
  always_ff @(posedge clk_i) begin
    if (in_i.valid && in_i.ready) begin
      act_q <= in_i.action;
      key_q <= in_i.key_down;
    end
    if (advance) begin
      led_q   <= led_d;
      ev_q    <= ev_d;
      edash_q <= edash_d;
      cv_q    <= cv_d;
      ch_q    <= ch_d;
    end
  end

  assign out_o.valid           = out_valid_q;
  assign out_o.led_on          = led_q;
  assign out_o.element_valid   = ev_q;
  assign out_o.element_is_dash = edash_q;
  assign out_o.char_valid      = cv_q;
  assign out_o.character       = ch_q;
  assign out_o.elements_held   = HELD_W'(elem_cnt_q);
  assign out_o.overflowed      = ovf_q;

  `MKD_ASSERT_NOW(a_count_bound, 1'b1, elem_cnt_q <= CntW'(MAX_ELEMENTS),
    "element count above buffer depth")
  `MKD_ASSERT_NOW(a_press_held, 1'b1, key_held_q == (press_q != '0),
    "press counter disagrees with key state")
  `MKD_ASSERT_NOW(a_one_event, out_valid_q, !(ev_q && cv_q),
    "element and character reported by one item")
  `MKD_ASSERT_NEXT(a_commit_empties, advance && (act_q == ACT_COMMIT),
    (elem_cnt_q == '0) && !ovf_q, "commit left the buffer filled")

endmodule

`default_nettype wire

// ===== test/morse_key_decoder_test.sv =====
// ---------------------------------------------------------------------------
// morse_key_decoder_test
// Self-checking bench for the Morse key decoder: keyed letters, noise and
// threshold changes go in, and every result item is checked field by field
// against an in-bench model of the press counter and element buffer.
// ---------------------------------------------------------------------------
`default_nettype none

module morse_key_decoder_test;

  import mkd_pkg::*;

  // The action field has one code that the block ignores.
  localparam logic [ACTION_W-1:0] ACT_IGNORED = 2'd3;

  localparam int unsigned RESET_CYCLES    = 5;
  localparam int unsigned HOLD_OFF_CYCLES = 64;
  localparam int unsigned RANDOM_ITEMS    = 330;
  localparam int unsigned LIMIT_CYCLES    = 1_000_000;
  localparam int unsigned PIPE_CYCLES     = 2;

  typedef struct packed {
    logic              led_on;
    logic              element_valid;
    logic              element_is_dash;
    logic              char_valid;
    logic [CHAR_W-1:0] character;
    logic [HELD_W-1:0] elements_held;
    logic              overflowed;
  } status_t;

  logic clk_i = 1'b0;
  logic rst_ni;

  mkd_in_if  key_ch ();
  mkd_out_if status_ch ();
  mkd_cfg_if cfg_ch ();

  morse_key_decoder i_dut (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .in_i   (key_ch),
    .out_o  (status_ch),
    .cfg_i  (cfg_ch)
  );

  always begin
    #6 clk_i = 1'b1;
    #6 clk_i = 1'b0;
  end

  // Decoder model state, mirrored from the block's reset values.
  logic [TICKS_W-1:0] dash_threshold  = DASH_THRESHOLD_RST;
  logic               key_is_down     = 1'b0;
  logic [TICKS_W-1:0] press_count     = '0;
  logic [4:0]         element_pattern = '0;
  int unsigned        element_total   = 0;
  logic               element_dropped = 1'b0;

  // Results predicted for accepted items, oldest first.
  status_t     pending_status[$];
  status_t     oldest_status;

  // Shared control between the stimulus, the result sink and the checker.
  bit          jitter_on     = 1'b1;
  bit          hold_off_req  = 1'b0;
  int unsigned items_sent    = 0;
  int unsigned cycle_count   = 0;
  int unsigned mismatches    = 0;

  // Tallies for the closing summary.
  int unsigned letters_decoded = 0;
  int unsigned letters_unknown = 0;
  int unsigned dots_keyed      = 0;
  int unsigned dashes_keyed    = 0;
  int unsigned drops_seen      = 0;

  // Map a buffered element pattern to its letter or digit; the pattern holds
  // the first element in the top used bit, with a dash as 1.
  function automatic logic [CHAR_W-1:0] letter_of(input logic [2:0] len,
                                                  input logic [4:0] pat);
    logic [7:0] ch;
    case ({len, pat})
      {3'd2, 5'b00001}: ch = "A";
      {3'd4, 5'b01000}: ch = "B";
      {3'd4, 5'b01010}: ch = "C";
      {3'd3, 5'b00100}: ch = "D";
      {3'd1, 5'b00000}: ch = "E";
      {3'd4, 5'b00010}: ch = "F";
      {3'd3, 5'b00110}: ch = "G";
      {3'd4, 5'b00000}: ch = "H";
      {3'd2, 5'b00000}: ch = "I";
      {3'd4, 5'b00111}: ch = "J";
      {3'd3, 5'b00101}: ch = "K";
      {3'd4, 5'b00100}: ch = "L";
      {3'd2, 5'b00011}: ch = "M";
      {3'd2, 5'b00010}: ch = "N";
      {3'd3, 5'b00111}: ch = "O";
      {3'd4, 5'b00110}: ch = "P";
      {3'd4, 5'b01101}: ch = "Q";
      {3'd3, 5'b00010}: ch = "R";
      {3'd3, 5'b00000}: ch = "S";
      {3'd1, 5'b00001}: ch = "T";
      {3'd3, 5'b00001}: ch = "U";
      {3'd4, 5'b00001}: ch = "V";
      {3'd3, 5'b00011}: ch = "W";
      {3'd4, 5'b01001}: ch = "X";
      {3'd4, 5'b01011}: ch = "Y";
      {3'd4, 5'b01100}: ch = "Z";
      {3'd5, 5'b11111}: ch = "0";
      {3'd5, 5'b01111}: ch = "1";
      {3'd5, 5'b00111}: ch = "2";
      {3'd5, 5'b00011}: ch = "3";
      {3'd5, 5'b00001}: ch = "4";
      {3'd5, 5'b00000}: ch = "5";
      {3'd5, 5'b10000}: ch = "6";
      {3'd5, 5'b11000}: ch = "7";
      {3'd5, 5'b11100}: ch = "8";
      {3'd5, 5'b11110}: ch = "9";
      default:          ch = {1'b0, CHAR_UNKNOWN};
    endcase
    return ch[CHAR_W-1:0];
  endfunction

  // Advance the model by one accepted item and return the result it owes.
  function automatic status_t predict_status(input logic [ACTION_W-1:0] act,
                                             input logic down);
    status_t s;
    logic    dash;
    s = '0;
    case (act)
      ACT_TICK: begin
        if (down) begin
          if (!key_is_down) begin
            key_is_down = 1'b1;
            press_count = 16'd1;
          end else if (press_count != TICKS_MAX) begin
            press_count = press_count + 16'd1;
          end
        end else if (key_is_down) begin
          dash        = (press_count > dash_threshold);
          key_is_down = 1'b0;
          press_count = '0;
          if (element_total < MAX_ELEMENTS_DEF) begin
            element_pattern   = {element_pattern[3:0], dash};
            element_total     = element_total + 1;
            s.element_valid   = 1'b1;
            s.element_is_dash = dash;
            if (dash) dashes_keyed++;
            else dots_keyed++;
          end else begin
            element_dropped = 1'b1;
            drops_seen++;
          end
        end
      end
      ACT_COMMIT: begin
        s.char_valid = 1'b1;
        if (element_dropped || element_total == 0) begin
          s.character = CHAR_UNKNOWN;
        end else begin
          s.character = letter_of(element_total[2:0], element_pattern);
        end
        if (s.character == CHAR_UNKNOWN) letters_unknown++;
        else letters_decoded++;
        element_pattern = '0;
        element_total   = 0;
        element_dropped = 1'b0;
      end
      ACT_CLEAR: begin
        element_pattern = '0;
        element_total   = 0;
        element_dropped = 1'b0;
      end
      default: ;
    endcase
    s.led_on        = key_is_down && (press_count <= dash_threshold);
    s.elements_held = element_total[HELD_W-1:0];
    s.overflowed    = element_dropped;
    return s;
  endfunction

  task automatic report_mismatch(input string what, input logic [15:0] got,
                                 input logic [15:0] want);
    $display("mismatch at cycle %0d: %s got %0h want %0h", cycle_count, what, got, want);
    mismatches++;
  endtask

  task automatic check_field(input string what, input logic [15:0] got,
                             input logic [15:0] want);
    if (got !== want) report_mismatch(what, got, want);
  endtask

  // Offer one item after a random gap when jitter is on, wait for the handshake, then predict.
  task automatic send_item(input logic [ACTION_W-1:0] act, input logic down);
    int unsigned gap;
    gap = jitter_on ? $urandom_range(0, 8) : 0;
    if (gap != 0) begin
      key_ch.valid <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    key_ch.valid    <= 1'b1;
    key_ch.action   <= act;
    key_ch.key_down <= down;
    do @(posedge clk_i); while (!key_ch.ready);
    pending_status.push_back(predict_status(act, down));
    if (act != ACT_IGNORED) items_sent++;
  endtask

  // Drop valid and hold until every predicted result has been checked.
  task automatic drain_results();
    key_ch.valid <= 1'b0;
    do @(posedge clk_i); while (pending_status.size() != 0);
  endtask

  task automatic write_threshold(input logic [TICKS_W-1:0] value);
    drain_results();
    repeat (PIPE_CYCLES) @(posedge clk_i);
    cfg_ch.valid <= 1'b1;
    cfg_ch.data  <= value;
    do @(posedge clk_i); while (!cfg_ch.ready);
    cfg_ch.valid <= 1'b0;
    dash_threshold = value;
  endtask

  // Hold the key for the given number of ticks, then release it.
  task automatic key_press(input int unsigned ticks);
    repeat (ticks) send_item(ACT_TICK, 1'b1);
    send_item(ACT_TICK, 1'b0);
  endtask

  // Key one dot or dash with a random length on the right side of the threshold.
  task automatic key_element(input logic dash);
    int unsigned ticks;
    if (dash || dash_threshold == 0) ticks = dash_threshold + $urandom_range(1, 3);
    else ticks = $urandom_range(1, dash_threshold);
    key_press(ticks);
  endtask

  // Key a whole letter, first element from the top bit, then commit it.
  task automatic key_letter(input int unsigned len, input logic [7:0] pat);
    for (int i = int'(len) - 1; i >= 0; i--) begin
      key_element(pat[i]);
      repeat ($urandom_range(0, 2)) send_item(ACT_TICK, 1'b0);
    end
    send_item(ACT_COMMIT, 1'(($urandom_range(0, 1))));
  endtask

  // Reset threshold: 500 ticks is still a dot, 501 is a dash, giving 'A'.
  task automatic test_reset_threshold();
    key_press(500);
    key_press(501);
    send_item(ACT_COMMIT, 1'b0);
  endtask

  task automatic test_directed_cases();
    write_threshold(16'd1);
    send_item(ACT_TICK, 1'b0);      // key up with no press in progress
    send_item(ACT_COMMIT, 1'b1);    // empty buffer decodes as unknown
    key_press(1);
    send_item(ACT_COMMIT, 1'b0);    // E
    key_press(2);
    send_item(ACT_COMMIT, 1'b0);    // T
    repeat (6) key_press(1);        // sixth element is dropped
    send_item(ACT_COMMIT, 1'b0);
    key_press(1);
    key_press(2);
    send_item(ACT_CLEAR, 1'b1);
    send_item(ACT_COMMIT, 1'b0);    // cleared, so unknown
    // A commit and a clear in the middle of a press leave the press counting.
    send_item(ACT_TICK, 1'b1);
    send_item(ACT_COMMIT, 1'b0);
    send_item(ACT_TICK, 1'b1);
    send_item(ACT_CLEAR, 1'b1);
    send_item(ACT_TICK, 1'b0);
    send_item(ACT_COMMIT, 1'b1);
    send_item(ACT_IGNORED, 1'b0);
    send_item(ACT_IGNORED, 1'b1);
    repeat (6) key_press(1);        // clear also drops the overflow flag
    send_item(ACT_CLEAR, 1'b0);
    send_item(ACT_COMMIT, 1'b0);
  endtask

  // Zero threshold makes every press a dash; the top one keeps short presses dots.
  task automatic test_threshold_extremes();
    write_threshold(16'd0);
    key_press(1);
    send_item(ACT_COMMIT, 1'b0);
    write_threshold(TICKS_MAX);
    key_press(3);
    send_item(ACT_COMMIT, 1'b0);
  endtask

  // Stall the result side for a long stretch while items keep coming.
  task automatic test_backpressure();
    write_threshold(16'd2);
    jitter_on    = 1'b0;
    hold_off_req = 1'b1;
    repeat (4) key_letter($urandom_range(1, 5), 8'($urandom_range(0, 31)));
    drain_results();
    jitter_on = 1'b1;
  endtask

  task automatic test_random_traffic();
    int unsigned goal;
    int unsigned pick;
    int unsigned len;
    goal = items_sent + RANDOM_ITEMS;
    while (items_sent < goal) begin
      if ($urandom_range(0, 7) == 0) jitter_on = ~jitter_on;
      pick = $urandom_range(0, 99);
      if (pick < 4) begin
        write_threshold(16'($urandom_range(0, 8)));
      end else if (pick < 72) begin
        len = $urandom_range(1, 5);
        key_letter(len, 8'($urandom_range(0, (1 << len) - 1)));
      end else if (pick < 82) begin
        key_letter($urandom_range(6, 8), 8'($urandom_range(0, 255)));
      end else begin
        // Noise: arbitrary actions and key levels, broken letters included.
        repeat ($urandom_range(1, 6)) begin
          send_item(ACTION_W'($urandom_range(0, 3)), 1'($urandom_range(0, 1)));
        end
      end
    end
    jitter_on = 1'b1;
  endtask

  // Result sink: stall before each item by a random gap when jitter is on, and honor
  // a request for one long hold-off.
  initial begin : result_sink
    int unsigned stall;
    status_ch.ready = 1'b0;
    wait (rst_ni === 1'b1);
    @(posedge clk_i);
    forever begin
      if (hold_off_req) begin
        hold_off_req = 1'b0;
        status_ch.ready <= 1'b0;
        repeat (HOLD_OFF_CYCLES) @(posedge clk_i);
      end
      stall = jitter_on ? $urandom_range(0, 8) : 0;
      if (stall != 0) begin
        status_ch.ready <= 1'b0;
        repeat (stall) @(posedge clk_i);
      end
      status_ch.ready <= 1'b1;
      do @(posedge clk_i); while (!status_ch.valid);
    end
  end

  // Check every accepted result against the oldest prediction.
  always @(posedge clk_i) begin
    if (rst_ni && status_ch.valid && status_ch.ready) begin
      if (pending_status.size() == 0) begin
        report_mismatch("result with nothing pending", '0, '0);
      end else begin
        oldest_status = pending_status.pop_front();
        check_field("led_on", status_ch.led_on, oldest_status.led_on);
        check_field("element_valid", status_ch.element_valid, oldest_status.element_valid);
        check_field("element_is_dash", status_ch.element_is_dash,
                    oldest_status.element_is_dash);
        check_field("char_valid", status_ch.char_valid, oldest_status.char_valid);
        check_field("character", status_ch.character, oldest_status.character);
        check_field("elements_held", status_ch.elements_held, oldest_status.elements_held);
        check_field("overflowed", status_ch.overflowed, oldest_status.overflowed);
      end
    end
  end

  // Watchdog: end a hung run.
  always @(posedge clk_i) begin
    cycle_count++;
    if (cycle_count > LIMIT_CYCLES) begin
      $display("tb: failure");
      $finish;
    end
  end

  initial begin
    rst_ni          = 1'b0;
    key_ch.valid    = 1'b0;
    key_ch.action   = ACT_TICK;
    key_ch.key_down = 1'b0;
    cfg_ch.valid    = 1'b0;
    cfg_ch.data     = '0;
    repeat (RESET_CYCLES) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    test_reset_threshold();
    test_directed_cases();
    test_threshold_extremes();
    test_backpressure();
    test_random_traffic();

    drain_results();
    repeat (PIPE_CYCLES + 2) @(posedge clk_i);
    $display("summary: %0d items, %0d letters decoded, %0d unknown, %0d dots, %0d dashes",
             items_sent, letters_decoded, letters_unknown, dots_keyed, dashes_keyed);
    $display("summary: %0d dropped elements, %0d mismatches over %0d cycles",
             drops_seen, mismatches, cycle_count);
    if (mismatches == 0) begin
      $display("tb: success");
    end else begin
      $display("tb: failure");
    end
    $finish;
  end

endmodule

`default_nettype wire
